// File: design/pbsg_pkg.sv
// pbsg_pkg: constants, types and arithmetic helpers for the brush stamp generator.
// Shared by procedural_brush_stamp_generator; no dependencies.
`default_nettype none
package pbsg_pkg;

	localparam int DEF_MAX_RES_LOG2 = 10;
	localparam int DEF_ALPHA_BITS   = 16;

	// config register indexes
	localparam int          CFG_IDX_W  = 1;
	localparam logic [0:0]  REG_PRESET = 1'd0;
	localparam logic [0:0]  REG_RES    = 1'd1;
	localparam int          CFG_DATA_W = 4;
	localparam logic [3:0]  RES_RESET  = 4'd7;
	localparam logic [3:0]  RES_MIN    = 4'd4;

	// preset codes
	localparam logic [1:0] PRESET_SOFT   = 2'd0;
	localparam logic [1:0] PRESET_RING   = 2'd1;
	localparam logic [1:0] PRESET_SQUARE = 2'd2;
	localparam logic [1:0] PRESET_GRUNGE = 2'd3;

	// Q16 shape constants
	localparam logic [16:0] ONE_Q16     = 17'd65536;
	localparam logic [16:0] RING_RADIUS = 17'd39322;
	localparam logic [16:0] RING_WIDTH  = 17'd18350;
	localparam logic [16:0] SQUARE_LO   = 17'd44892;
	localparam logic [16:0] SQUARE_HI   = 17'd46203;
	localparam logic [16:0] EDGE_LO     = 17'd45875;
	localparam logic [17:0] SMOOTH_K    = 18'd196608;

	// ramp divisors and reciprocals, floor(2^33 / D)
	localparam logic [16:0] RMP_D_SOFT   = ONE_Q16;
	localparam logic [16:0] RMP_D_RING   = RING_WIDTH;
	localparam logic [16:0] RMP_D_SQUARE = SQUARE_HI - SQUARE_LO;
	localparam logic [16:0] RMP_D_EDGE   = ONE_Q16 - EDGE_LO;
	localparam logic [23:0] RMP_R_SOFT   = 24'((64'd1 << 33) / 64'(RMP_D_SOFT));
	localparam logic [23:0] RMP_R_RING   = 24'((64'd1 << 33) / 64'(RMP_D_RING));
	localparam logic [23:0] RMP_R_SQUARE = 24'((64'd1 << 33) / 64'(RMP_D_SQUARE));
	localparam logic [23:0] RMP_R_EDGE   = 24'((64'd1 << 33) / 64'(RMP_D_EDGE));

	// noise shaping in Q0.24, reciprocal floor(2^39 / D)
	localparam logic [23:0] NOISE_LO = 24'd5872026;
	localparam logic [23:0] NOISE_HI = 24'd12582912;
	localparam logic [22:0] NOISE_D  = 23'(NOISE_HI - NOISE_LO);
	localparam logic [16:0] NOISE_R  = 17'((64'd1 << 39) / 64'(NOISE_D));
	localparam logic [21:0] NOISE_BIAS = 22'd1048576;

	// lattice hash
	localparam logic [31:0] HASH_CX  = 32'd374761393;
	localparam logic [31:0] HASH_CY  = 32'd668265263;
	localparam logic [31:0] HASH_MIX = 32'd1274126177;

	// square root: 17 result bits, two per stage, one in the last
	localparam int ISQ_ITERS  = 17;
	localparam int ISQ_STAGES = 9;
	localparam int ISQ_TOP    = 32;

	localparam int FIFO_AW    = 5;
	localparam int FIFO_DEPTH = 32;

	typedef struct packed {
		logic [34:0] rem;
		logic [34:0] root;
	} isq_t;

	function automatic isq_t isq_step(input isq_t s, input int idx);
		isq_t        o;
		logic [34:0] bitv;
		logic [34:0] trial;
		bitv  = 35'd1 << (ISQ_TOP - 2 * idx);
		trial = s.root + bitv;
		if (s.rem >= trial) begin
			o.rem  = s.rem - trial;
			o.root = (s.root >> 1) + bitv;
		end else begin
			o.rem  = s.rem;
			o.root = s.root >> 1;
		end
		return o;
	endfunction

	// second half of smoothstep: qq = q*q from the stage before
	function automatic logic [16:0] smooth_fin(input logic [33:0] qq, input logic [16:0] q);
		logic [51:0] p;
		p = 52'(qq) * 52'(SMOOTH_K - {q, 1'b0});
		return p[48:32];
	endfunction

	function automatic logic [31:0] hash_pre(input logic [4:0] x, input logic [4:0] y);
		logic [31:0] xe;
		logic [31:0] ye;
		xe = {{27{x[4]}}, x};
		ye = {{27{y[4]}}, y};
		return xe * HASH_CX + ye * HASH_CY;
	endfunction

	function automatic logic [31:0] hash_mix(input logic [31:0] h);
		logic [31:0] t;
		t = h ^ (h >> 13);
		return t * HASH_MIX;
	endfunction

endpackage
`default_nettype wire

// File: design/procedural_brush_stamp_generator.sv
// procedural_brush_stamp_generator: per-texel brush alpha (soft, ring, square, grunge).
// Uses pbsg_pkg for constants, square-root step, smoothstep and hash helpers.
// Throughput one item per cycle while s_tready is high.
// Pipeline is free running; a 32-entry output FIFO with credit count holds results,
// so s_tready drops only when 32 items are outstanding. Reset (arst_n low) empties
// the pipeline and FIFO, sets preset to soft and resolution_log2 to 7.
`default_nettype none
module procedural_brush_stamp_generator #(
	parameter int MAX_RES_LOG2 = pbsg_pkg::DEF_MAX_RES_LOG2,
	parameter int ALPHA_BITS   = pbsg_pkg::DEF_ALPHA_BITS
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	// config write port
	input  wire logic                                     cfg_we,
	input  wire logic [pbsg_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  wire logic [pbsg_pkg::CFG_DATA_W-1:0]          cfg_data,
	// input items
	input  wire logic                                     s_tvalid,
	output logic                                          s_tready,
	input  wire logic [((2*MAX_RES_LOG2+7)/8)*8-1:0]      s_tdata,  // pixel_x, pixel_y
	// result items
	output logic                                          m_tvalid,
	input  wire logic                                     m_tready,
	output logic [((ALPHA_BITS+7)/8)*8-1:0]               m_tdata   // alpha_value
);
	import pbsg_pkg::*;

	localparam int MR     = MAX_RES_LOG2;
	localparam int M_W    = ((ALPHA_BITS + 7) / 8) * 8;
	localparam int OUT_W  = ALPHA_BITS + 18;
	localparam int NSTAGE = 18;

	// ---------------- configuration ----------------
	logic [1:0] preset_q;
	logic [3:0] res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_q <= PRESET_SOFT;
			res_q    <= RES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRESET: preset_q <= cfg_data[1:0];
				REG_RES:    res_q    <= cfg_data;
				default:    ;
			endcase
		end
	end

	// ---------------- handshake / credits ----------------
	logic                 in_acc, out_acc;
	logic [FIFO_AW:0]     inflight_q;
	logic [FIFO_AW:0]     fcnt_q;
	logic [FIFO_AW-1:0]   wptr_q, rptr_q;
	logic [ALPHA_BITS-1:0] fifo_mem_q [FIFO_DEPTH];
	logic                 valid_s [1:NSTAGE];
	logic [ALPHA_BITS-1:0] code_s18;

	// credit count covers items in the pipeline plus items in the FIFO
	assign s_tready = (inflight_q < (FIFO_AW + 1)'(FIFO_DEPTH));
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = (fcnt_q != '0);
	assign out_acc  = m_tvalid && m_tready;
	assign m_tdata  = M_W'(fifo_mem_q[rptr_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			fcnt_q     <= '0;
			wptr_q     <= '0;
			rptr_q     <= '0;
			for (int i = 1; i <= NSTAGE; i++) valid_s[i] <= 1'b0;
		end else begin
			valid_s[1] <= in_acc;
			for (int i = 2; i <= NSTAGE; i++) valid_s[i] <= valid_s[i-1];
			inflight_q <= inflight_q + (FIFO_AW + 1)'(in_acc) - (FIFO_AW + 1)'(out_acc);
			fcnt_q     <= fcnt_q + (FIFO_AW + 1)'(valid_s[NSTAGE]) - (FIFO_AW + 1)'(out_acc);
			if (valid_s[NSTAGE]) wptr_q <= wptr_q + 1'b1;
			if (out_acc)         rptr_q <= rptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s[NSTAGE]) fifo_mem_q[wptr_q] <= code_s18;
	end

	// ---------------- stage 1: texel center in Q2.16 ----------------
	logic [MR-1:0]   px, py, pmask;
	logic [3:0]      lc;
	logic [16:0]     shx, shy;
	logic signed [17:0] u_s1, v_s1;
	logic [1:0]      pre_s [1:17];

	always_comb begin
		if (res_q < RES_MIN)            lc = RES_MIN;
		else if (res_q > 4'(MR))        lc = 4'(MR);
		else                            lc = res_q;
		pmask = ~({MR{1'b1}} << lc);
		px    = s_tdata[MR-1:0] & pmask;
		py    = s_tdata[2*MR-1:MR] & pmask;
		shx   = 17'({px, 1'b1}) << (5'd16 - 5'(lc));
		shy   = 17'({py, 1'b1}) << (5'd16 - 5'(lc));
	end

	always_ff @(posedge clk) begin
		u_s1     <= signed'({1'b0, shx}) - 18'sd65536;
		v_s1     <= signed'({1'b0, shy}) - 18'sd65536;
		pre_s[1] <= preset_q;
		for (int i = 2; i <= 17; i++) pre_s[i] <= pre_s[i-1];
	end

	// ---------------- stage 2: magnitudes, squares, noise lattice split ----------------
	logic [16:0] au, av;
	logic [20:0] u6, v6;
	logic [21:0] bu, bv;
	logic [33:0] squ_s2, sqv_s2;
	logic [16:0] md_s [2:12];
	logic [4:0]  x0_s2, y0_s2;
	logic [15:0] tx_s2, ty_s2;

	always_comb begin
		au = u_s1[17] ? 17'(-u_s1) : 17'(u_s1);
		av = v_s1[17] ? 17'(-v_s1) : 17'(v_s1);
		u6 = {{3{u_s1[17]}}, u_s1} * 21'd6;
		v6 = {{3{v_s1[17]}}, v_s1} * 21'd6;
		bu = {u6[20], u6} + NOISE_BIAS;
		bv = {v6[20], v6} + NOISE_BIAS;
	end

	always_ff @(posedge clk) begin
		squ_s2   <= 34'(au) * 34'(au);
		sqv_s2   <= 34'(av) * 34'(av);
		md_s[2]  <= (au > av) ? au : av;
		for (int i = 3; i <= 12; i++) md_s[i] <= md_s[i-1];
		x0_s2    <= 5'(bu[21:16] - 6'd16);
		y0_s2    <= 5'(bv[21:16] - 6'd16);
		tx_s2    <= bu[15:0];
		ty_s2    <= bv[15:0];
	end

	// ---------------- stage 3: radius squared, hash pre-sums, smoothstep squares ----------------
	logic [33:0] n_s3;
	logic [31:0] ha_s3, hb_s3, hc_s3, hd_s3;
	logic [31:0] qqx_s3, qqy_s3;
	logic [15:0] tx_s3, ty_s3;
	logic [4:0]  x1, y1;

	assign x1 = x0_s2 + 5'd1;
	assign y1 = y0_s2 + 5'd1;

	always_ff @(posedge clk) begin
		n_s3   <= squ_s2 + sqv_s2;
		ha_s3  <= hash_pre(x0_s2, y0_s2);
		hb_s3  <= hash_pre(x1, y0_s2);
		hc_s3  <= hash_pre(x0_s2, y1);
		hd_s3  <= hash_pre(x1, y1);
		qqx_s3 <= 32'(tx_s2) * 32'(tx_s2);
		qqy_s3 <= 32'(ty_s2) * 32'(ty_s2);
		tx_s3  <= tx_s2;
		ty_s3  <= ty_s2;
	end

	// ---------------- stages 4..12: square root, two bits per stage ----------------
	isq_t isq_s [4:12];

	for (genvar k = 0; k < ISQ_STAGES; k++) begin : g_isq
		isq_t in_w, mid_w, out_w;
		if (k == 0) begin : g_first
			assign in_w = '{rem: 35'(n_s3), root: '0};
		end else begin : g_next
			assign in_w = isq_s[3+k];
		end
		assign mid_w = isq_step(in_w, 2 * k);
		if (2 * k + 1 < ISQ_ITERS) begin : g_two
			assign out_w = isq_step(mid_w, 2 * k + 1);
		end else begin : g_one
			assign out_w = mid_w;
		end
		always_ff @(posedge clk) begin
			isq_s[4+k] <= out_w;
		end
	end

	// ---------------- noise path, stages 4..13 ----------------
	logic [31:0] hm_s4 [4];
	logic [16:0] sx_s4, sy_s4, sx_s5, sy_s5, sy_s6, sy_s7;
	logic [23:0] lat_s5 [4];
	logic [40:0] pa_s6, pb_s6, pc_s6, pd_s6;
	logic [23:0] top_s7, bot_s7;
	logic [40:0] pt_s8, pbt_s8;
	logic [23:0] noise_s9;
	logic        nlo_s10, nhi_s10;
	logic [22:0] ntt_s10;
	logic [16:0] nqe_s10;
	logic [16:0] nq_s11, nq_s12;
	logic [33:0] nqq_s12;
	logic [16:0] nsh_s [13:16];
	logic [22:0] ntt;
	logic [39:0] nprod, nchk;
	logic [40:0] sa6, sb6;
	logic [40:0] sn9;

	assign ntt   = 23'(noise_s9 - NOISE_LO);
	assign nprod = 40'(ntt) * 40'(NOISE_R);
	assign nchk  = 40'(nqe_s10 + 17'd1) * 40'(NOISE_D);
	assign sa6   = 41'(pa_s6) + 41'(pb_s6);
	assign sb6   = 41'(pc_s6) + 41'(pd_s6);
	assign sn9   = 41'(pt_s8) + 41'(pbt_s8);

	always_ff @(posedge clk) begin
		// s4: hash mix, smoothstep weights
		hm_s4[0] <= hash_mix(ha_s3);
		hm_s4[1] <= hash_mix(hb_s3);
		hm_s4[2] <= hash_mix(hc_s3);
		hm_s4[3] <= hash_mix(hd_s3);
		sx_s4    <= smooth_fin(34'(qqx_s3), 17'(tx_s3));
		sy_s4    <= smooth_fin(34'(qqy_s3), 17'(ty_s3));
		// s5: lattice values in Q0.24
		for (int i = 0; i < 4; i++) lat_s5[i] <= 24'(hm_s4[i] ^ (hm_s4[i] >> 16));
		sx_s5    <= sx_s4;
		sy_s5    <= sy_s4;
		// s6: x blend products
		pa_s6    <= 41'(lat_s5[0]) * 41'(ONE_Q16 - sx_s5);
		pb_s6    <= 41'(lat_s5[1]) * 41'(sx_s5);
		pc_s6    <= 41'(lat_s5[2]) * 41'(ONE_Q16 - sx_s5);
		pd_s6    <= 41'(lat_s5[3]) * 41'(sx_s5);
		sy_s6    <= sy_s5;
		// s7: x blend sums
		top_s7   <= sa6[39:16];
		bot_s7   <= sb6[39:16];
		sy_s7    <= sy_s6;
		// s8: y blend products
		pt_s8    <= 41'(top_s7) * 41'(ONE_Q16 - sy_s7);
		pbt_s8   <= 41'(bot_s7) * 41'(sy_s7);
		// s9: value noise
		noise_s9 <= sn9[39:16];
		// s10: noise ramp, reciprocal estimate
		nlo_s10  <= (noise_s9 <= NOISE_LO);
		nhi_s10  <= (noise_s9 >= NOISE_HI);
		ntt_s10  <= ntt;
		nqe_s10  <= nprod[39:23];
		// s11: one-step correction
		if (nlo_s10)      nq_s11 <= '0;
		else if (nhi_s10) nq_s11 <= ONE_Q16;
		else if (nchk <= {1'b0, ntt_s10, 16'd0}) nq_s11 <= nqe_s10 + 17'd1;
		else              nq_s11 <= nqe_s10;
		// s12, s13: smoothstep
		nq_s12   <= nq_s11;
		nqq_s12  <= 34'(nq_s11) * 34'(nq_s11);
		nsh_s[13] <= smooth_fin(nqq_s12, nq_s12);
		for (int i = 14; i <= 16; i++) nsh_s[i] <= nsh_s[i-1];
	end

	// ---------------- stages 13..16: shape ramp and smoothstep ----------------
	logic [16:0] r, rt, rlo, rhi, rd, tt;
	logic [23:0] rr;
	logic [40:0] rprod;
	logic        le_s13, ge_s13;
	logic [16:0] tt_s13, qe_s13, d_s13;
	logic [16:0] q1_s14, q1_s15, a1_s16;
	logic [33:0] qq1_s15;
	logic [33:0] rchk;

	assign r = isq_s[12].root[16:0];

	always_comb begin
		unique case (pre_s[12])
			PRESET_SOFT: begin
				rt = r;  rlo = '0;  rhi = ONE_Q16;  rd = RMP_D_SOFT;  rr = RMP_R_SOFT;
			end
			PRESET_RING: begin
				rt  = (r >= RING_RADIUS) ? r - RING_RADIUS : RING_RADIUS - r;
				rlo = '0;  rhi = RING_WIDTH;  rd = RMP_D_RING;  rr = RMP_R_RING;
			end
			PRESET_SQUARE: begin
				rt = md_s[12];  rlo = SQUARE_LO;  rhi = SQUARE_HI;
				rd = RMP_D_SQUARE;  rr = RMP_R_SQUARE;
			end
			PRESET_GRUNGE: begin
				rt = r;  rlo = EDGE_LO;  rhi = ONE_Q16;  rd = RMP_D_EDGE;  rr = RMP_R_EDGE;
			end
			default: begin
				rt = r;  rlo = '0;  rhi = ONE_Q16;  rd = RMP_D_SOFT;  rr = RMP_R_SOFT;
			end
		endcase
		tt    = rt - rlo;
		rprod = 41'(tt) * 41'(rr);
	end

	assign rchk = 34'(qe_s13 + 17'd1) * 34'(d_s13);

	always_ff @(posedge clk) begin
		le_s13  <= (rt <= rlo);
		ge_s13  <= (rt >= rhi);
		tt_s13  <= tt;
		qe_s13  <= rprod[33:17];
		d_s13   <= rd;
		if (le_s13)      q1_s14 <= '0;
		else if (ge_s13) q1_s14 <= ONE_Q16;
		else if (rchk <= {1'b0, tt_s13, 16'd0}) q1_s14 <= qe_s13 + 17'd1;
		else             q1_s14 <= qe_s13;
		q1_s15  <= q1_s14;
		qq1_s15 <= 34'(q1_s14) * 34'(q1_s14);
		a1_s16  <= ONE_Q16 - smooth_fin(qq1_s15, q1_s15);
	end

	// ---------------- stage 17: grunge combine, clamp; stage 18: output code ----------------
	logic [16:0]      alpha_s17;
	logic [33:0]      gprod;
	logic [16:0]      amix;
	logic [OUT_W-1:0] oscale;

	assign gprod = 34'(nsh_s[16]) * 34'(a1_s16);

	always_comb begin
		if (pre_s[16] == PRESET_GRUNGE) amix = gprod[32:16];
		else                            amix = a1_s16;
		// A*(2^ALPHA_BITS - 1) + 0.5, by shift and subtract
		oscale = {1'b0, alpha_s17, {ALPHA_BITS{1'b0}}} - OUT_W'(alpha_s17) + OUT_W'(32768);
	end

	always_ff @(posedge clk) begin
		alpha_s17 <= (amix > ONE_Q16) ? ONE_Q16 : amix;
		code_s18  <= oscale[16 +: ALPHA_BITS];
	end

	// pre_s[17] tags the item at the clamp stage (stage 17); unused beyond the grunge select
	logic unused_pre;
	assign unused_pre = ^pre_s[17] ^ ^isq_s[12].rem ^ ^isq_s[12].root[34:17]
		^ ^s_tdata ^ ^md_s[2] ^ ^pre_s[13] ^ ^pre_s[14] ^ ^pre_s[15] ^ ^valid_s[1];

endmodule
`default_nettype wire
